// ===== design/weighted_overlap_add_synthesis_core_defines.svh =====
// Assertion macros for the weighted overlap-add synthesis core.
`ifndef WEIGHTED_OVERLAP_ADD_SYNTHESIS_CORE_DEFINES_SVH
`define WEIGHTED_OVERLAP_ADD_SYNTHESIS_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// checked outside reset
`define WOLA_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define WOLA_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define WOLA_ASSERT(lbl, prop, msg)
`define WOLA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== design/wola_pkg.sv =====
// Shared constants, types and helpers of the overlap-add synthesis core.
package wola_pkg;
   localparam int MAX_WINDOW  = 1024;
   localparam int ADDR_W      = $clog2(MAX_WINDOW);
   localparam int LEN_W       = $clog2(MAX_WINDOW + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int ACTION_W = 2;
   localparam int INDEX_W  = 10;
   localparam int COEFF_W  = 16;
   localparam int HOP_W    = 11;
   localparam int SAMPLE_W = 16;
   localparam int CFG_W    = 11;
   localparam int SUM_W    = 48;
   localparam int RING_W   = 2 * SUM_W;

   localparam logic [ACTION_W-1:0] ACT_LOAD   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_FLUSH  = 2'd2;

   localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = 11'd1024;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_SAMPLE,
      CMD_FLUSH
   } wola_kind_type;

   typedef struct packed {
      wola_kind_type              kind;
      logic                       emit;
      logic                       last;
      logic [ADDR_W-1:0]          emit_slot;
      logic [ADDR_W-1:0]          acc_slot;
      logic [ADDR_W-1:0]          widx;
      logic [COEFF_W-1:0]         coeff;
      logic signed [SAMPLE_W-1:0] sample;
   } wola_cmd_type;

   typedef struct packed {
      logic clearing;
      logic idle;
   } wola_back_stat_type;

   typedef struct packed {
      logic full;
      logic empty;
   } wola_q_stat_type;

   // (a + b) modulo MAX_WINDOW for a, b below MAX_WINDOW + 1 with sum below twice it
   function automatic logic [ADDR_W-1:0] wrap_add(input logic [LEN_W-1:0] a,
                                                  input logic [LEN_W-1:0] b);
      logic [LEN_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (LEN_W + 1)'(MAX_WINDOW)) s = s - (LEN_W + 1)'(MAX_WINDOW);
      return s[ADDR_W-1:0];
   endfunction
endpackage

// ===== design/wola_if.sv =====
// Channel interfaces: request, response and register write.
interface wola_req_if import wola_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic [INDEX_W-1:0]         window_index;
   logic [COEFF_W-1:0]         window_coeff;
   logic [HOP_W-1:0]           hop;
   logic signed [SAMPLE_W-1:0] frame_sample;
   modport source (output valid, action, window_index, window_coeff, hop, frame_sample,
                   input ready);
   modport sink (input valid, action, window_index, window_coeff, hop, frame_sample,
                 output ready);
endinterface

interface wola_rsp_if import wola_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] output_sample;
   logic                       last;
   modport source (output valid, output_sample, last, input ready);
   modport sink (input valid, output_sample, last, output ready);
endinterface

interface wola_csr_if import wola_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] write_data;
   modport source (output valid, write_data, input ready);
   modport sink (input valid, write_data, output ready);
endinterface

// ===== design/weighted_overlap_add_synthesis_core.sv =====
// Top level of the weighted overlap-add synthesis core.
//
//   channel   direction  beat contents
//   req_bus   in         action, window_index, window_coeff, hop, frame_sample
//   rsp_bus   out        output_sample, last
//   csr_bus   in         write_data (window_length)
//
// Steps: a window load is written from idle; a frame sample that emits nothing only
// accumulates. An emitting sample or a flush beat reads and clears its slot, then runs
// the 16-step restoring divider; an overflowing quotient ends it at the first step.
// Reset: synchronous; afterwards all 1024 ring slots are swept to zero
// with req_bus held off. The final flush beat starts the same sweep.
// Stalls: a 4-entry command queue decouples the front from the back; rsp_bus has
// its own output register, so a stalled response holds only the back part.
`include "weighted_overlap_add_synthesis_core_defines.svh"
module weighted_overlap_add_synthesis_core import wola_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wola_req_if.sink   req_bus,
   wola_rsp_if.source rsp_bus,
   wola_csr_if.sink   csr_bus
);
   wola_cmd_type       push_cmd;
   wola_cmd_type       head;
   logic               push;
   logic               pop;
   wola_q_stat_type    q_stat;
   wola_back_stat_type back_stat;

   // classify beats and track frame position, hop and ring base
   wola_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .csr       (csr_bus),
      .q_stat    (q_stat),
      .back_stat (back_stat),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // hold commands until the back part drains them
   wola_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .stat     (q_stat)
   );

   // ring update, normalize and respond
   wola_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .q_stat (q_stat),
      .pop    (pop),
      .stat   (back_stat),
      .rsp    (rsp_bus)
   );

   `WOLA_ASSERT(a_no_push_when_full, push |-> !q_stat.full, "command pushed into full queue")
   `WOLA_ASSERT(a_no_req_in_sweep, (req_bus.valid && req_bus.ready) |-> !back_stat.clearing, "request beat taken during ring sweep")
   `WOLA_ASSERT(a_sweep_after_reset, $past(reset) |-> back_stat.clearing, "ring sweep not running after reset")
   `WOLA_ASSERT(a_pop_only_idle, pop |-> (back_stat.idle && !q_stat.empty), "queue popped outside idle")
endmodule

// ===== design/wola_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module wola_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== design/wola_queue.sv =====
// Short command queue between the front and back parts.
module wola_queue import wola_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  wola_cmd_type    push_cmd,
   input  logic            pop,
   output wola_cmd_type    head,
   output wola_q_stat_type stat
);
   wola_cmd_type      entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end
endmodule

// ===== design/wola_front.sv =====
// Front part: takes request beats, tracks frame position and hop, builds commands.
module wola_front import wola_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   wola_req_if.sink           req,
   wola_csr_if.sink           csr,
   input  wola_q_stat_type    q_stat,
   input  wola_back_stat_type back_stat,
   output logic               push,
   output wola_cmd_type       push_cmd
);
   logic [CFG_W-1:0]  window_length_ff;
   logic [ADDR_W-1:0] ring_base_ff, ring_base_in;
   logic [ADDR_W-1:0] position_ff, position_in;
   logic [LEN_W-1:0]  hop_ff, hop_in;
   logic              first_ff, first_in;
   logic [ADDR_W-1:0] flush_count_ff, flush_count_in;
   logic [LEN_W-1:0]  eff;
   logic [ADDR_W-1:0] p0;
   logic              accept;

   assign csr.ready = 1'b1;
   assign req.ready = !q_stat.full && !back_stat.clearing;
   assign accept    = req.valid && req.ready;

   always_comb begin
      if (window_length_ff == '0) eff = LEN_W'(1);
      else if (int'(window_length_ff) > MAX_WINDOW) eff = LEN_W'(MAX_WINDOW);
      else eff = LEN_W'(window_length_ff);
   end

   always_comb begin
      ring_base_in   = ring_base_ff;
      position_in    = position_ff;
      hop_in         = hop_ff;
      first_in       = first_ff;
      flush_count_in = flush_count_ff;
      push           = 1'b0;
      p0             = (LEN_W'(position_ff) >= eff) ? '0 : position_ff;
      push_cmd.kind      = CMD_LOAD;
      push_cmd.emit      = 1'b0;
      push_cmd.last      = 1'b0;
      push_cmd.emit_slot = '0;
      push_cmd.acc_slot  = '0;
      push_cmd.widx      = ADDR_W'(req.window_index);
      push_cmd.coeff     = req.window_coeff;
      push_cmd.sample    = req.frame_sample;
      if (accept) begin
         case (req.action)
            ACT_LOAD: begin
               push = (int'(req.window_index) < MAX_WINDOW);
            end
            ACT_SAMPLE: begin
               push           = 1'b1;
               push_cmd.kind  = CMD_SAMPLE;
               flush_count_in = '0;
               if (p0 == '0) begin
                  if (first_ff) begin
                     first_in = 1'b0;
                     hop_in   = '0;
                  end else begin
                     // clamp the hop to the window in use
                     hop_in = (int'(req.hop) > int'(eff)) ? eff : LEN_W'(req.hop);
                     ring_base_in = wrap_add(LEN_W'(ring_base_ff), hop_in);
                  end
               end
               push_cmd.widx      = p0;
               push_cmd.emit      = (LEN_W'(p0) < hop_in);
               push_cmd.emit_slot = wrap_add(LEN_W'(ring_base_in),
                                             LEN_W'(MAX_WINDOW) - hop_in + LEN_W'(p0));
               push_cmd.acc_slot  = wrap_add(LEN_W'(ring_base_in), LEN_W'(p0));
               position_in = ((LEN_W'(p0) + LEN_W'(1)) >= eff) ? '0 : p0 + 1'b1;
            end
            ACT_FLUSH: begin
               push               = 1'b1;
               push_cmd.kind      = CMD_FLUSH;
               push_cmd.emit      = 1'b1;
               push_cmd.emit_slot = wrap_add(LEN_W'(ring_base_ff), LEN_W'(flush_count_ff));
               push_cmd.last      = ((LEN_W'(flush_count_ff) + LEN_W'(1)) >= eff);
               position_in        = '0;
               if (push_cmd.last) begin
                  // restart from a clean ring; the back part sweeps the memory
                  ring_base_in   = '0;
                  hop_in         = '0;
                  first_in       = 1'b1;
                  flush_count_in = '0;
               end else begin
                  flush_count_in = flush_count_ff + 1'b1;
               end
            end
            default: begin
               push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= WINDOW_LENGTH_RESET;
         ring_base_ff     <= '0;
         position_ff      <= '0;
         hop_ff           <= '0;
         first_ff         <= 1'b1;
         flush_count_ff   <= '0;
      end else begin
         if (csr.valid && csr.ready) window_length_ff <= csr.write_data;
         ring_base_ff   <= ring_base_in;
         position_ff    <= position_in;
         hop_ff         <= hop_in;
         first_ff       <= first_in;
         flush_count_ff <= flush_count_in;
      end
   end
endmodule

// ===== design/wola_back.sv =====
// Back part: ring read-modify-write, normalizing divide, response register, clear sweep.
module wola_back import wola_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  wola_cmd_type       head,
   input  wola_q_stat_type    q_stat,
   output logic               pop,
   output wola_back_stat_type stat,
   wola_rsp_if.source         rsp
);
   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_ERD, S_ECAP, S_NUM, S_CHK, S_DIV, S_EOUT, S_ARD, S_AMUL, S_AWR
   } state_type;

   localparam logic [SUM_W-1:0] ONE_Q230 = SUM_W'(64'd1 << 30);

   state_type                  state_ff, state_in;
   wola_cmd_type               cmd_ff, cmd_in;
   logic [ADDR_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic [SUM_W-1:0]           en_ff, en_in;
   logic                       neg_ff, neg_in;
   logic [SUM_W-1:0]           dvs_ff, dvs_in;
   logic [62:0]                rem_ff, rem_in;
   logic [62:0]                dsh_ff, dsh_in;
   logic [15:0]                q_ff, q_in;
   logic                       ovf_ff, ovf_in;
   logic [3:0]                 bit_ff, bit_in;
   logic signed [32:0]         prod_ff, prod_in;
   logic [31:0]                sq_ff, sq_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       ring_we, win_we;
   logic [ADDR_W-1:0]          ring_waddr, ring_raddr, win_raddr;
   logic [RING_W-1:0]          ring_wdata, ring_rdata;
   logic [COEFF_W-1:0]         win_rdata;
   logic signed [SUM_W-1:0]    rd_sum;
   logic [SUM_W:0]             acc_sum, acc_en;
   logic [SUM_W-1:0]           sat_sum, sat_en;
   logic [SAMPLE_W-1:0]        result;

   wola_ram #(.WIDTH(RING_W), .DEPTH(MAX_WINDOW)) u_ring (
      .clock (clock),
      .we    (ring_we),
      .waddr (ring_waddr),
      .wdata (ring_wdata),
      .raddr (ring_raddr),
      .rdata (ring_rdata)
   );

   wola_ram #(.WIDTH(COEFF_W), .DEPTH(MAX_WINDOW)) u_window (
      .clock (clock),
      .we    (win_we),
      .waddr (head.widx),
      .wdata (head.coeff),
      .raddr (win_raddr),
      .rdata (win_rdata)
   );

   assign stat.clearing     = (state_ff == S_CLEAR);
   assign stat.idle         = (state_ff == S_IDLE);
   assign rsp.valid         = rsp_valid_ff;
   assign rsp.output_sample = rsp_data_ff;
   assign rsp.last          = rsp_last_ff;
   assign rd_sum            = ring_rdata[RING_W-1:SUM_W];

   // saturating accumulate of the weighted sample and the squared weight
   always_comb begin
      acc_sum = {sum_ff[SUM_W-1], sum_ff} + {{(SUM_W - 32){prod_ff[32]}}, prod_ff};
      if (acc_sum[SUM_W] != acc_sum[SUM_W-1]) begin
         sat_sum = acc_sum[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}} : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sat_sum = acc_sum[SUM_W-1:0];
      end
      acc_en = {1'b0, en_ff} + (SUM_W + 1)'(sq_ff);
      sat_en = acc_en[SUM_W] ? '1 : acc_en[SUM_W-1:0];
   end

   // round-to-nearest quotient, saturated to 16 bits
   always_comb begin
      if (neg_ff) begin
         result = (ovf_ff || q_ff > 16'd32768) ? 16'h8000 : 16'd0 - q_ff;
      end else begin
         result = (ovf_ff || q_ff > 16'd32767) ? 16'h7FFF : q_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      clr_cnt_in   = clr_cnt_ff;
      sum_in       = sum_ff;
      en_in        = en_ff;
      neg_in       = neg_ff;
      dvs_in       = dvs_ff;
      rem_in       = rem_ff;
      dsh_in       = dsh_ff;
      q_in         = q_ff;
      ovf_in       = ovf_ff;
      bit_in       = bit_ff;
      prod_in      = prod_ff;
      sq_in        = sq_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      pop          = 1'b0;
      win_we       = 1'b0;
      ring_we      = 1'b0;
      ring_waddr   = cmd_ff.emit_slot;
      ring_wdata   = '0;
      ring_raddr   = cmd_ff.emit_slot;
      win_raddr    = cmd_ff.widx;
      unique case (state_ff)
         S_CLEAR: begin
            ring_we    = 1'b1;
            ring_waddr = clr_cnt_ff;
            if (clr_cnt_ff == ADDR_W'(MAX_WINDOW - 1)) begin
               clr_cnt_in = '0;
               state_in   = S_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (!q_stat.empty) begin
               pop    = 1'b1;
               cmd_in = head;
               unique case (head.kind)
                  CMD_LOAD:   win_we   = 1'b1;
                  CMD_SAMPLE: state_in = head.emit ? S_ERD : S_ARD;
                  CMD_FLUSH:  state_in = S_ERD;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_ERD: begin
            state_in = S_ECAP;
         end
         S_ECAP: begin
            // take the slot's sums, then clear it for reuse
            ring_we = 1'b1;
            neg_in  = rd_sum[SUM_W-1];
            rem_in  = 63'(rd_sum[SUM_W-1] ? SUM_W'(0) - SUM_W'(rd_sum) : SUM_W'(rd_sum));
            dvs_in  = (ring_rdata[SUM_W-1:0] == '0) ? ONE_Q230 : ring_rdata[SUM_W-1:0];
            state_in = S_NUM;
         end
         S_NUM: begin
            rem_in   = (rem_ff << 15) + 63'(dvs_ff >> 1);
            state_in = S_CHK;
         end
         S_CHK: begin
            ovf_in   = ({1'b0, rem_ff} >= {dvs_ff, 16'd0});
            dsh_in   = {dvs_ff, 15'd0};
            q_in     = '0;
            bit_in   = 4'd15;
            state_in = S_DIV;
         end
         S_DIV: begin
            // one quotient bit per cycle
            if (rem_ff >= dsh_ff) begin
               rem_in = rem_ff - dsh_ff;
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               q_in   = {q_ff[14:0], 1'b0};
            end
            dsh_in = dsh_ff >> 1;
            bit_in = bit_ff - 1'b1;
            if (ovf_ff || bit_ff == '0) state_in = S_EOUT;
         end
         S_EOUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result;
               rsp_last_in  = cmd_ff.last;
               if (cmd_ff.kind == CMD_SAMPLE) state_in = S_ARD;
               else if (cmd_ff.last) state_in = S_CLEAR;
               else state_in = S_IDLE;
            end
         end
         S_ARD: begin
            ring_raddr = cmd_ff.acc_slot;
            state_in   = S_AMUL;
         end
         S_AMUL: begin
            prod_in  = $signed({1'b0, win_rdata}) * cmd_ff.sample;
            sq_in    = win_rdata * win_rdata;
            sum_in   = rd_sum;
            en_in    = ring_rdata[SUM_W-1:0];
            state_in = S_AWR;
         end
         S_AWR: begin
            ring_we    = 1'b1;
            ring_waddr = cmd_ff.acc_slot;
            ring_wdata = {sat_sum, sat_en};
            state_in   = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      sum_ff      <= sum_in;
      en_ff       <= en_in;
      neg_ff      <= neg_in;
      dvs_ff      <= dvs_in;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      q_ff        <= q_in;
      ovf_ff      <= ovf_in;
      bit_ff      <= bit_in;
      prod_ff     <= prod_in;
      sq_ff       <= sq_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end
endmodule
